// File: hdl/mcc_pkg.sv
// mcc_pkg: widths, mode and register codes, reset values, item types and helpers
// for the charge controller. Depends on nothing; imported by every hdl file but mcc_fifo.
package mcc_pkg;

    localparam int V_W    = 13;
    localparam int I_W    = 16;
    localparam int IRR_W  = 10;
    localparam int P_W    = 19;
    localparam int DUTY_W = 8;
    localparam int MODE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int AVG_DEPTH_DEF   = 5;
    localparam int SLOW_PERIOD_DEF = 50;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MPPT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NIGHT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERROR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DONE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_START_POWER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_IRR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_POWER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_IRR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOUT_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOUT_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_HIGH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_LOW    = 3'd7;

    localparam logic [P_W-1:0]   RST_START_POWER = 19'd100;
    localparam logic [IRR_W-1:0] RST_NIGHT_IRR   = 10'd1000;
    localparam logic [P_W-1:0]   RST_NIGHT_POWER = 19'd400;
    localparam logic [IRR_W-1:0] RST_WAKE_IRR    = 10'd500;
    localparam logic [V_W-1:0]   RST_VOUT_MAX    = 13'd5200;
    localparam logic [V_W-1:0]   RST_VOUT_MIN    = 13'd4500;
    localparam logic [V_W-1:0]   RST_TRIM_HIGH   = 13'd5150;
    localparam logic [V_W-1:0]   RST_TRIM_LOW    = 13'd4550;

    localparam logic [DUTY_W-1:0] RST_DUTY     = 8'd10;
    localparam logic [DUTY_W-1:0] IDLE_DUTY_MAX = 8'd150;
    localparam logic [V_W-1:0]    IDLE_VIN_MV   = 13'd5000;
    localparam logic [IRR_W-1:0]  DONE_IRR      = 10'd200;
    localparam logic signed [I_W-1:0]  DONE_IIN_MA = 16'sd50;
    localparam logic signed [16:0]     TRIM_STEP_MAX = 17'sd200;

    // floor(x/1000) for x < 2^28, floor(x/5000) for x < 2^21
    localparam int PROD_W   = 28;
    localparam int MW_SH    = 38;
    localparam int MW_M_W   = 29;
    localparam logic [MW_M_W-1:0] MW_M = MW_M_W'(((64'd1 << MW_SH) + 64'd999) / 64'd1000);
    localparam int IDLE_T_W = 21;
    localparam int ID_SH    = 34;
    localparam int ID_M_W   = 22;
    localparam logic [ID_M_W-1:0] ID_M = ID_M_W'(((64'd1 << ID_SH) + 64'd4999) / 64'd5000);

    typedef struct packed {
        logic [P_W-1:0]   start_power;
        logic [IRR_W-1:0] night_irr;
        logic [P_W-1:0]   night_power;
        logic [IRR_W-1:0] wake_irr;
        logic [V_W-1:0]   vout_max;
        logic [V_W-1:0]   vout_min;
        logic [V_W-1:0]   trim_high;
        logic [V_W-1:0]   trim_low;
    } t_cfg;

    typedef struct packed {
        logic [V_W-1:0]    vout;
        logic [I_W-1:0]    iin;
        logic [IRR_W-1:0]  irr;
        logic              valid;
        logic [P_W-1:0]    power;
        logic [DUTY_W-1:0] idle_duty;
    } t_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [MODE_W-1:0] mode;
        logic              relay_on;
        logic              sample_valid;
        logic [P_W-1:0]    avg_power;
    } t_res;

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [9:0] d);
        logic [DUTY_W-1:0] r;
        if (d < 10'sd0) begin
            r = '0;
        end else if (d > 10'sd255) begin
            r = '1;
        end else begin
            r = d[DUTY_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/mcc_fifo.sv
// mcc_fifo: small first-in first-out queue with an occupancy count.
// Depends on nothing; used between front and back and on the result side.
module mcc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [W-1:0]               i_wdata,
    input  logic                       i_rd,
    output logic [W-1:0]               o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_rdata = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_wr) - CW'(i_rd);
        end
    end
endmodule

// File: hdl/mcc_front.sv
// mcc_front: accepts samples, classifies them and works out power and idle duty.
// Depends on mcc_pkg; feeds the front-to-back queue.
module mcc_front
    import mcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [V_W-1:0]    i_vin_mv,
    input  logic [V_W-1:0]    i_vout_mv,
    input  logic [I_W-1:0]    i_iin_ma,
    input  logic [IRR_W-1:0]  i_irradiance,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_queue_count,
    output logic              o_full,
    output logic              o_wr,
    output t_item             o_item
);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic                r_f0v, r_f1v;
    logic [V_W-1:0]      r_f0_vout;
    logic [I_W-1:0]      r_f0_iin;
    logic [IRR_W-1:0]    r_f0_irr;
    logic                r_f0_valid;
    logic [PROD_W-1:0]   r_f0_prod;
    logic [IDLE_T_W-1:0] r_f0_t;
    t_item               r_f1;

    logic                n_valid;
    logic [V_W-1:0]      n_diff;
    logic [PROD_W+MW_M_W-1:0]   p_prod;
    logic [IDLE_T_W+ID_M_W-1:0] d_prod;
    logic [DUTY_W-1:0]   d_q;

    assign n_valid = !i_iin_ma[I_W-1] && (i_iin_ma != '0);
    assign n_diff  = (i_vin_mv < IDLE_VIN_MV) ? IDLE_VIN_MV - i_vin_mv : '0;
    assign p_prod  = (PROD_W+MW_M_W)'(r_f0_prod) * (PROD_W+MW_M_W)'(MW_M);
    assign d_prod  = (IDLE_T_W+ID_M_W)'(r_f0_t) * (IDLE_T_W+ID_M_W)'(ID_M);
    assign d_q     = d_prod[ID_SH +: DUTY_W];

    assign o_full = (CW+1)'(i_queue_count) + (CW+1)'(r_f0v) + (CW+1)'(r_f1v)
                    >= (CW+1)'(QUEUE_DEPTH);
    assign o_wr   = r_f1v;
    assign o_item = r_f1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0v <= 1'b0;
            r_f1v <= 1'b0;
        end else begin
            r_f0v <= i_accept;
            r_f1v <= r_f0v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f0_vout  <= i_vout_mv;
        r_f0_iin   <= i_iin_ma;
        r_f0_irr   <= i_irradiance;
        r_f0_valid <= n_valid;
        r_f0_prod  <= n_valid ? PROD_W'(i_vin_mv) * PROD_W'(i_iin_ma[I_W-2:0]) : '0;
        r_f0_t     <= ({8'd0, n_diff} << 8) - {8'd0, n_diff};
        r_f1.vout      <= r_f0_vout;
        r_f1.iin       <= r_f0_iin;
        r_f1.irr       <= r_f0_irr;
        r_f1.valid     <= r_f0_valid;
        r_f1.power     <= p_prod[MW_SH +: P_W];
        r_f1.idle_duty <= (d_q > IDLE_DUTY_MAX) ? IDLE_DUTY_MAX : d_q;
    end
endmodule

// File: hdl/mcc_back.sv
// mcc_back: moving average, mode machine, trim and perturb-and-observe step.
// Depends on mcc_pkg; drains the front-to-back queue into the result queue.
module mcc_back
    import mcc_pkg::*;
#(
    parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
    parameter int SLOW_PERIOD = SLOW_PERIOD_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_avail,
    input  t_item i_item,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_out_count,
    output logic  o_rd,
    output logic  o_wr,
    output t_res  o_res
);
    localparam int CW    = $clog2(QUEUE_DEPTH+1);
    localparam int LD    = $clog2(AVG_DEPTH);
    localparam int IW    = (LD > 0) ? LD : 1;
    localparam int SUM_W = P_W + LD;
    localparam int A_SH  = SUM_W + LD;
    localparam int A_M_W = SUM_W + 2;
    localparam logic [A_M_W-1:0] A_M =
        A_M_W'(((64'd1 << A_SH) + 64'(AVG_DEPTH - 1)) / 64'(AVG_DEPTH));
    localparam int TW    = $clog2(SLOW_PERIOD + 2);
    localparam logic [TW-1:0] SP = TW'(SLOW_PERIOD);

    logic [P_W-1:0]   r_win [AVG_DEPTH];
    logic [IW-1:0]    r_idx;
    logic [SUM_W-1:0] r_sum;
    logic             r_s1v, r_s2v;
    t_item            r_s1, r_s2;
    logic [P_W-1:0]   r_avg;

    logic [P_W-1:0]          r_prev;
    logic signed [I_W-1:0]   r_slow;
    logic signed [I_W:0]     r_cur;
    logic [MODE_W-1:0]       r_mode;
    logic [DUTY_W-1:0]       r_duty;
    logic                    r_dir;
    logic [TW-1:0]           r_tick;
    logic                    r_relay;

    logic [P_W-1:0]          n_prev;
    logic signed [I_W-1:0]   n_slow;
    logic signed [I_W:0]     n_cur;
    logic [MODE_W-1:0]       n_mode;
    logic [DUTY_W-1:0]       n_duty;
    logic                    n_dir;
    logic [TW-1:0]           n_tick;
    logic                    n_relay;

    logic [SUM_W+A_M_W-1:0]  a_prod;
    logic signed [9:0]       d;
    logic                    trim_ok;
    logic [TW-1:0]           cnt;

    assign o_rd = i_avail && ((CW+1)'(i_out_count) + (CW+1)'(r_s1v) + (CW+1)'(r_s2v)
                  < (CW+1)'(QUEUE_DEPTH));
    assign a_prod = (SUM_W+A_M_W)'(r_sum) * (SUM_W+A_M_W)'(A_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_idx <= '0;
            r_sum <= '0;
            r_avg <= '0;
            for (int k = 0; k < AVG_DEPTH; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_s1v <= o_rd;
            r_s2v <= r_s1v;
            if (o_rd && i_item.valid) begin
                r_sum <= r_sum - SUM_W'(r_win[r_idx]) + SUM_W'(i_item.power);
                r_win[r_idx] <= i_item.power;
                r_idx <= (r_idx == IW'(AVG_DEPTH-1)) ? '0 : r_idx + 1'b1;
            end
            if (r_s1v && r_s1.valid) begin
                r_avg <= a_prod[A_SH +: P_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= i_item;
        r_s2 <= r_s1;
    end

    always_comb begin
        n_prev  = r_prev;
        n_slow  = r_slow;
        n_cur   = r_cur;
        n_mode  = r_mode;
        n_duty  = r_duty;
        n_dir   = r_dir;
        n_tick  = r_tick;
        n_relay = r_relay;
        d       = '0;
        trim_ok = 1'b0;
        cnt     = r_tick;
        if (r_s2v) begin
            if (r_s2.valid) begin
                n_cur = $signed({r_s2.iin[I_W-1], r_s2.iin}) - $signed({r_slow[I_W-1], r_slow});
            end
            case (r_mode)
                MODE_IDLE: begin
                    n_relay = 1'b1;
                    n_duty  = r_s2.idle_duty;
                    if (r_avg > i_cfg.start_power) n_mode = MODE_MPPT;
                end
                MODE_MPPT: begin
                    n_relay = 1'b1;
                    if (r_s2.irr > i_cfg.night_irr && r_avg < i_cfg.night_power) begin
                        n_mode = MODE_NIGHT;
                    end else if (r_s2.vout > i_cfg.vout_max || r_s2.vout < i_cfg.vout_min) begin
                        n_mode = MODE_ERROR;
                    end
                end
                MODE_NIGHT: begin
                    n_duty = '0;
                    if (r_s2.irr < i_cfg.wake_irr && r_s2.vout < i_cfg.vout_max
                        && r_s2.vout > i_cfg.vout_min) begin
                        n_mode = MODE_MPPT;
                    end
                end
                MODE_ERROR: begin
                    n_relay = 1'b0;
                end
                MODE_DONE: begin
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
            if (n_mode == MODE_MPPT) begin
                d = $signed({2'b00, n_duty});
                trim_ok = n_cur < TRIM_STEP_MAX;
                if (r_s2.vout > i_cfg.trim_high && trim_ok) d = d - 10'sd1;
                if (r_s2.vout < i_cfg.trim_low && trim_ok) begin
                    n_dir = ~n_dir;
                    d = n_dir ? d - 10'sd1 : d + 10'sd1;
                end
                if (r_s2.vout < i_cfg.trim_low) d = d + 10'sd1;
                n_duty = clamp_duty(d);
            end
            if (cnt == SP && n_mode == MODE_MPPT) begin
                n_prev = r_avg;
                if (r_s2.valid) begin
                    if (r_s2.irr < DONE_IRR && $signed(r_s2.iin) < DONE_IIN_MA) begin
                        n_mode = MODE_DONE;
                    end
                    if (r_avg < r_prev) n_dir = ~n_dir;
                    n_duty = clamp_duty(n_dir ? $signed({2'b00, n_duty}) - 10'sd1
                                              : $signed({2'b00, n_duty}) + 10'sd1);
                    n_slow = $signed(r_s2.iin);
                end
                cnt = '0;
            end else if (cnt == SP && (n_mode == MODE_NIGHT || n_mode == MODE_ERROR
                                       || n_mode == MODE_DONE)) begin
                n_relay = 1'b0;
                cnt = '0;
            end
            cnt = cnt + 1'b1;
            n_tick = (cnt > SP) ? '0 : cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_slow  <= '0;
            r_cur   <= '0;
            r_mode  <= MODE_IDLE;
            r_duty  <= RST_DUTY;
            r_dir   <= 1'b0;
            r_tick  <= '0;
            r_relay <= 1'b0;
        end else begin
            r_prev  <= n_prev;
            r_slow  <= n_slow;
            r_cur   <= n_cur;
            r_mode  <= n_mode;
            r_duty  <= n_duty;
            r_dir   <= n_dir;
            r_tick  <= n_tick;
            r_relay <= n_relay;
        end
    end

    assign o_wr               = r_s2v;
    assign o_res.duty         = n_duty;
    assign o_res.mode         = n_mode;
    assign o_res.relay_on     = n_relay;
    assign o_res.sample_valid = r_s2.valid;
    assign o_res.avg_power    = r_avg;
endmodule

// File: hdl/mppt_charge_controller.sv
// mppt_charge_controller: top level with configuration registers, front, queues, back.
// Depends on mcc_pkg, mcc_fifo, mcc_front and mcc_back.
//
//  channel   handshake                    payload
//  samples   push / full                  i_vin_mv i_vout_mv i_iin_ma i_irradiance
//  results   empty / pop                  o_duty o_mode o_relay_on o_sample_valid o_avg_power_mw
//  config    i_cfg_valid / o_cfg_ready    i_cfg_index i_cfg_data
//
// One sample per cycle sustained while full is low; a pushed sample passes two front stages,
// the queue, two averaging stages and the combinational mode logic into the result queue.
// Reset is synchronous and takes effect at once; no clearing pass.
// full rises when the front queue and front stages hold four items; the back
// stalls when the result queue cannot take what is in flight. Config is always ready.
module mppt_charge_controller
    import mcc_pkg::*;
#(
    parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
    parameter int SLOW_PERIOD = SLOW_PERIOD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [V_W-1:0]        i_vin_mv,
    input  logic [V_W-1:0]        i_vout_mv,
    input  logic [I_W-1:0]        i_iin_ma,
    input  logic [IRR_W-1:0]      i_irradiance,
    output logic                  empty,
    input  logic                  pop,
    output logic [DUTY_W-1:0]     o_duty,
    output logic [MODE_W-1:0]     o_mode,
    output logic                  o_relay_on,
    output logic                  o_sample_valid,
    output logic [P_W-1:0]        o_avg_power_mw,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    t_cfg          r_cfg;
    logic          f_wr, b_rd, b_wr, out_rd;
    t_item         f_item, m_item;
    t_res          b_res, o_res;
    logic [CW-1:0] m_cnt, o_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_power <= RST_START_POWER;
            r_cfg.night_irr   <= RST_NIGHT_IRR;
            r_cfg.night_power <= RST_NIGHT_POWER;
            r_cfg.wake_irr    <= RST_WAKE_IRR;
            r_cfg.vout_max    <= RST_VOUT_MAX;
            r_cfg.vout_min    <= RST_VOUT_MIN;
            r_cfg.trim_high   <= RST_TRIM_HIGH;
            r_cfg.trim_low    <= RST_TRIM_LOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_POWER: r_cfg.start_power <= i_cfg_data;
                REG_NIGHT_IRR:   r_cfg.night_irr   <= i_cfg_data[IRR_W-1:0];
                REG_NIGHT_POWER: r_cfg.night_power <= i_cfg_data;
                REG_WAKE_IRR:    r_cfg.wake_irr    <= i_cfg_data[IRR_W-1:0];
                REG_VOUT_MAX:    r_cfg.vout_max    <= i_cfg_data[V_W-1:0];
                REG_VOUT_MIN:    r_cfg.vout_min    <= i_cfg_data[V_W-1:0];
                REG_TRIM_HIGH:   r_cfg.trim_high   <= i_cfg_data[V_W-1:0];
                REG_TRIM_LOW:    r_cfg.trim_low    <= i_cfg_data[V_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mcc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (push && !full),
        .i_vin_mv     (i_vin_mv),
        .i_vout_mv    (i_vout_mv),
        .i_iin_ma     (i_iin_ma),
        .i_irradiance (i_irradiance),
        .i_queue_count(m_cnt),
        .o_full       (full),
        .o_wr         (f_wr),
        .o_item       (f_item)
    );

    mcc_fifo #(.W($bits(t_item)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (f_wr),
        .i_wdata(f_item),
        .i_rd   (b_rd),
        .o_rdata(m_item),
        .o_count(m_cnt)
    );

    mcc_back #(.AVG_DEPTH(AVG_DEPTH), .SLOW_PERIOD(SLOW_PERIOD)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_avail    (m_cnt != '0),
        .i_item     (m_item),
        .i_out_count(o_cnt),
        .o_rd       (b_rd),
        .o_wr       (b_wr),
        .o_res      (b_res)
    );

    assign out_rd = pop && !empty;

    mcc_fifo #(.W($bits(t_res)), .DEPTH(QUEUE_DEPTH)) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (b_wr),
        .i_wdata(b_res),
        .i_rd   (out_rd),
        .o_rdata(o_res),
        .o_count(o_cnt)
    );

    assign empty          = (o_cnt == '0);
    assign o_duty         = o_res.duty;
    assign o_mode         = o_res.mode;
    assign o_relay_on     = o_res.relay_on;
    assign o_sample_valid = o_res.sample_valid;
    assign o_avg_power_mw = o_res.avg_power;
endmodule
